// ----- src/rpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the cordic arctangent table for the
// rectangular/polar converter; no dependencies
package rpc_pkg;

    typedef logic        [1:0]  t_func;
    typedef logic signed [15:0] t_val;
    typedef logic        [15:0] t_mag;

    // operand forms
    localparam t_func FORM_RECT  = 2'd0;
    localparam t_func FORM_POLAR = 2'd1;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned TAB_LEN          = 24;
    localparam int unsigned GUARD            = 14;
    // internal x/y width: q8.8 input, 14 guard bits, cordic growth, sign
    localparam int unsigned XW               = 33;
    localparam int unsigned ZW               = 32;

    // 1/K in q0.32
    localparam logic [31:0] GAIN = 32'd2608131496;

    // degrees q10.6 to binary angle: round(|a| * 2^23 / 45)
    // 2^23 = 45 * 186413 + 23, so q = |a|*186413 + floor((23*|a| + 22) / 45)
    localparam logic [17:0] DEG_MUL    = 18'd186413;
    localparam logic [4:0]  DEG_REM    = 5'd23;
    localparam logic [4:0]  DEG_BIAS   = 5'd22;
    // floor(f / 45) = (f * 1491309) >> 26 for f below 2^20
    localparam logic [20:0] DEG_RECIP  = 21'd1491309;
    localparam int unsigned DEG_RSHIFT = 26;

    // atan(2^-i) with 2^31 = pi
    function automatic logic [31:0] atan_val(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/rpc_in_if.sv -----
`timescale 1ns / 1ps
// input channel of the rectangular/polar converter: valid/ready plus operands
// depends on rpc_pkg
interface rpc_in_if;
    logic               valid;
    logic               ready;
    rpc_pkg::t_func     func;
    rpc_pkg::t_val      first_value;
    rpc_pkg::t_val      second_value;

    modport source (output valid, output func, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input func, input first_value, input second_value,
                    output ready);
endinterface

// ----- src/rpc_out_if.sv -----
`timescale 1ns / 1ps
// output channel of the rectangular/polar converter: valid/ready plus results
// depends on rpc_pkg
interface rpc_out_if;
    logic               valid;
    logic               ready;
    rpc_pkg::t_val      x_out;
    rpc_pkg::t_val      y_out;
    rpc_pkg::t_mag      magnitude;
    rpc_pkg::t_val      angle;
    logic               bad_form;

    modport source (output valid, output x_out, output y_out, output magnitude,
                    output angle, output bad_form, input ready);
    modport sink   (input valid, input x_out, input y_out, input magnitude,
                    input angle, input bad_form, output ready);
endinterface

// ----- src/rect_polar_converter_unit.sv -----
`timescale 1ns / 1ps
// top level of the rectangular/polar converter: unrolled, fully pipelined cordic
// depends on rpc_pkg, rpc_in_if, rpc_out_if
//
// Converts one vector per clock while the skid entry is empty. A rectangular
// transaction (func 0) returns x and y unchanged together with the magnitude and the
// binary angle (32768 = pi) found by cordic vectoring; the zero vector gives
// magnitude and angle 0. A polar transaction (func 1) takes a q8.8 magnitude and a
// q10.6 angle in degrees and returns x and y by cordic rotation, with |magnitude| and
// the converted angle echoed. func 2 or 3 gives all-zero results with bad_form set.
// A new transaction is accepted every cycle while the skid entry is empty; the result
// passes through four stages of degree conversion, one set-up stage, one stage per
// cordic iteration, a gain multiply stage, a rounding/saturation stage and the output
// register. The whole pipeline advances together; a two-entry output register (output
// plus skid) keeps ready registered, so input can still be taken after the sink stops,
// until a result lands in the skid entry. CORDIC_STEPS above 24 acts as 24.

module rect_polar_converter_unit #(
    parameter int unsigned CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpc_in_if.sink      i_item,
    rpc_out_if.source   o_result
);

    localparam int unsigned N = (CORDIC_STEPS > rpc_pkg::TAB_LEN) ?
                                rpc_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int unsigned XW = rpc_pkg::XW;
    localparam int unsigned PW = XW + 33;

    // stage numbering
    localparam int unsigned ST_ABS  = 0;
    localparam int unsigned ST_MUL  = 1;
    localparam int unsigned ST_FRAC = 2;
    localparam int unsigned ST_ZIN  = 3;
    localparam int unsigned ST_INIT = 4;
    localparam int unsigned ST_PROD = ST_INIT + N + 1;
    localparam int unsigned ST_FIN  = ST_PROD + 1;
    localparam int unsigned NS      = ST_FIN + 1;

    localparam logic signed [PW-1:0] RND = PW'(1) <<< (31 + rpc_pkg::GUARD);
    localparam int unsigned          UNSCALE_SHIFT = 32 + rpc_pkg::GUARD;

    // operands and per-item flags that ride along with every stage
    typedef struct packed {
        rpc_pkg::t_func func;
        rpc_pkg::t_val  a;
        rpc_pkg::t_val  b;
        logic           zero;
        rpc_pkg::t_val  ang;
    } t_side;

    typedef struct packed {
        rpc_pkg::t_val  x_out;
        rpc_pkg::t_val  y_out;
        rpc_pkg::t_mag  magnitude;
        rpc_pkg::t_val  angle;
        logic           bad_form;
    } t_res;

    function automatic rpc_pkg::t_val sat16(input logic signed [PW-1:0] v);
        rpc_pkg::t_val r;
        if (v > PW'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -PW'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // pipeline control
    logic [NS-1:0]  r_vld;
    logic           w_en;

    // stage payload
    t_side                  r_side [NS];
    t_side                  n_side [NS];
    logic [15:0]            r_bab;
    logic                   n_bneg;
    logic [15:0]            n_bab;
    logic [33:0]            r_p1;
    logic [19:0]            r_f;
    logic [33:0]            r_p1b;
    logic [14:0]            r_qf;
    logic [40:0]            w_p2;
    logic [33:0]            w_q;
    logic [31:0]            r_zin;
    logic [31:0]            n_zin;
    logic [31:0]            w_zin_rnd;
    logic [31:0]            w_zang_rnd;
    logic signed [XW-1:0]   r_x [N+1];
    logic signed [XW-1:0]   r_y [N+1];
    logic [31:0]            r_z [N+1];
    logic signed [XW-1:0]   n_x [N+1];
    logic signed [XW-1:0]   n_y [N+1];
    logic [31:0]            n_z [N+1];
    logic signed [XW-1:0]   w_xa;
    logic signed [XW-1:0]   w_yb;
    logic signed [PW-1:0]   r_px;
    logic signed [PW-1:0]   r_py;
    logic signed [PW-1:0]   w_vx;
    logic signed [PW-1:0]   w_vy;
    t_res                   r_res;
    t_res                   n_res;

    // output register and skid
    t_res   r_od;
    t_res   r_sd;
    logic   r_ov;
    logic   r_sv;
    logic   w_take;
    logic   w_in_res;

    // everything moves together unless the skid entry is holding a result
    assign w_en         = ~r_sv;
    assign i_item.ready = w_en;
    assign w_take       = r_ov & o_result.ready;
    assign w_in_res     = r_vld[NS-1] & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_item.valid};
        end
    end

    // degree to binary angle conversion, spread over four stages
    assign n_bneg = i_item.second_value[15];
    assign n_bab  = n_bneg ? 16'(-i_item.second_value) : 16'(i_item.second_value);
    assign w_p2   = 41'(r_f) * 41'(rpc_pkg::DEG_RECIP);
    assign w_q    = r_p1b + 34'(r_qf);
    assign n_zin  = r_side[ST_FRAC].b[15] ? (32'd0 - w_q[31:0]) : w_q[31:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bab <= n_bab;
            r_p1  <= 34'(r_bab) * 34'(rpc_pkg::DEG_MUL);
            r_f   <= (20'(r_bab) * 20'(rpc_pkg::DEG_REM)) + 20'(rpc_pkg::DEG_BIAS);
            r_p1b <= r_p1;
            r_qf  <= w_p2[rpc_pkg::DEG_RSHIFT +: 15];
            r_zin <= n_zin;
        end
    end

    // cordic set-up and iterations
    assign w_xa = {{(XW - 16 - rpc_pkg::GUARD){r_side[ST_ZIN].a[15]}},
                   r_side[ST_ZIN].a, {rpc_pkg::GUARD{1'b0}}};
    assign w_yb = {{(XW - 16 - rpc_pkg::GUARD){r_side[ST_ZIN].b[15]}},
                   r_side[ST_ZIN].b, {rpc_pkg::GUARD{1'b0}}};

    always_comb begin
        if (r_side[ST_ZIN].func == rpc_pkg::FORM_RECT) begin
            // fold the left half plane onto the right, starting from pi
            if (r_side[ST_ZIN].a[15]) begin
                n_x[0] = -w_xa;
                n_y[0] = -w_yb;
                n_z[0] = 32'h8000_0000;
            end else begin
                n_x[0] = w_xa;
                n_y[0] = w_yb;
                n_z[0] = '0;
            end
        end else begin
            // angles in the second and third quadrant rotate by pi first
            n_y[0] = '0;
            if (r_zin[31] ^ r_zin[30]) begin
                n_x[0] = -w_xa;
                n_z[0] = r_zin ^ 32'h8000_0000;
            end else begin
                n_x[0] = w_xa;
                n_z[0] = r_zin;
            end
        end
        for (int i = 0; i < N; i++) begin
            // vectoring steers y toward zero, rotation steers z toward zero
            if ((r_side[ST_INIT + i].func == rpc_pkg::FORM_RECT) ?
                    ~r_y[i][XW-1] : r_z[i][31]) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + rpc_pkg::atan_val(i);
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - rpc_pkg::atan_val(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // side data chain, with the angle filled in where it becomes known
    assign w_zin_rnd  = r_zin + 32'h0000_8000;
    assign w_zang_rnd = r_z[N] + 32'h0000_8000;

    always_comb begin
        n_side[0] = '{func: i_item.func, a: i_item.first_value, b: i_item.second_value,
                      zero: (i_item.first_value == '0) && (i_item.second_value == '0),
                      ang: '0};
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[ST_INIT].ang = w_zin_rnd[31:16];
        if (r_side[ST_PROD-1].func == rpc_pkg::FORM_RECT) begin
            n_side[ST_PROD].ang = w_zang_rnd[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
        end
    end

    // gain removal: one multiply stage, then round and saturate
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= PW'(r_x[N]) * PW'(signed'({1'b0, rpc_pkg::GAIN}));
            r_py <= PW'(r_y[N]) * PW'(signed'({1'b0, rpc_pkg::GAIN}));
        end
    end

    assign w_vx = (r_px + RND) >>> UNSCALE_SHIFT;
    assign w_vy = (r_py + RND) >>> UNSCALE_SHIFT;

    always_comb begin
        n_res = '0;
        case (r_side[ST_PROD].func)
            rpc_pkg::FORM_RECT: begin
                n_res.x_out = r_side[ST_PROD].a;
                n_res.y_out = r_side[ST_PROD].b;
                if (!r_side[ST_PROD].zero) begin
                    if (w_vx[PW-1]) begin
                        n_res.magnitude = '0;
                    end else if (w_vx > PW'(65535)) begin
                        n_res.magnitude = 16'hffff;
                    end else begin
                        n_res.magnitude = w_vx[15:0];
                    end
                    n_res.angle = r_side[ST_PROD].ang;
                end
            end
            rpc_pkg::FORM_POLAR: begin
                n_res.x_out     = sat16(w_vx);
                n_res.y_out     = sat16(w_vy);
                n_res.magnitude = r_side[ST_PROD].a[15] ? 16'(-r_side[ST_PROD].a)
                                                        : 16'(r_side[ST_PROD].a);
                n_res.angle     = r_side[ST_PROD].ang;
            end
            default: begin
                n_res.bad_form = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_in_res) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_res && (!r_ov || w_take)) begin
            r_od <= r_res;
        end else if (w_in_res) begin
            r_sd <= r_res;
        end else if (w_take && r_sv) begin
            r_od <= r_sd;
        end
    end

    assign o_result.valid     = r_ov;
    assign o_result.x_out     = r_od.x_out;
    assign o_result.y_out     = r_od.y_out;
    assign o_result.magnitude = r_od.magnitude;
    assign o_result.angle     = r_od.angle;
    assign o_result.bad_form  = r_od.bad_form;

    // skid entry is only ever used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds a transaction while output register is empty");

    // skid fills only after the sink refused a waiting result
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(o_result.valid && !o_result.ready))
        else $error("skid entry filled without back pressure");

    // a stalled pipeline keeps every transaction in place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // invalid forms come out as an all-zero vector
    a_bad_form_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.bad_form) |->
            (o_result.x_out == '0 && o_result.y_out == '0 &&
             o_result.magnitude == '0 && o_result.angle == '0))
        else $error("bad_form result carries nonzero fields");

endmodule
